/* rtl/pixel_insertion_sorter_defines.svh */
// assertion macros shared by the pixel insertion sorter modules
`ifndef PIXEL_INSERTION_SORTER_DEFINES_SVH
`define PIXEL_INSERTION_SORTER_DEFINES_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define PIS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pis check failed");

// next-cycle implication, sampled on clock, quiet during reset
`define PIS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pis check failed");

`endif

/* rtl/pis_pkg.sv */
// types and constants for the pixel insertion sorter
package pis_pkg;

   localparam int PIXEL_W = 8;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // controller states
   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic      occupied;
      logic      greater;
      pixel_type value;
   } link_type;

   // command broadcast to every cell
   typedef struct packed {
      logic      insert;
      logic      shift_out;
      pixel_type value;
   } cmd_type;

   // chain status seen by the controller
   typedef struct packed {
      logic full;
      logic second_occupied;
   } chain_status_type;

endpackage

/* rtl/pis_cell.sv */
// one compare-and-shift cell of the sorting chain
module pis_cell
   import pis_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  link_type left,
   input  link_type right,
   output link_type self
);

   pixel_type value_ff, value_in;
   logic      occupied_ff, occupied_in;
   logic      greater;
   logic      take;

   // held value sits above the new pixel: it moves one place right
   assign greater = occupied_ff && (value_ff > cmd.value);
   // take a value if shifting, or if this is the first empty cell
   assign take    = greater || (left.occupied && !occupied_ff);

   assign self.occupied = occupied_ff;
   assign self.greater  = greater;
   assign self.value    = value_ff;

   // next cell contents
   always_comb begin
      value_in    = value_ff;
      occupied_in = occupied_ff;
      if (cmd.shift_out) begin
         value_in    = right.value;
         occupied_in = right.occupied;
      end else if (cmd.insert && take) begin
         value_in    = left.greater ? left.value : cmd.value;
         occupied_in = 1'b1;
      end
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= 1'b0;
      end else begin
         occupied_ff <= occupied_in;
      end
   end

   // stored pixel
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* rtl/pis_ctrl.sv */
// fill and drain sequencer for the sorting chain
`include "pixel_insertion_sorter_defines.svh"

module pis_ctrl
   import pis_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pixel_type        req_pixel_value,
   input  logic             req_run_end,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_final_value,
   output logic             rsp_overflowed,
   input  chain_status_type status,
   output cmd_type          cmd
);

   state_type state_ff, state_in;
   logic      overflow_ff, overflow_in;

   // state and overflow registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_FILL;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   // next state and chain commands
   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      cmd.value   = req_pixel_value;
      case (state_ff)
         ST_FILL: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.insert = !status.full;
               if (status.full) begin
                  overflow_in = 1'b1;
               end
               if (req_run_end) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.shift_out = 1'b1;
               if (!status.second_occupied) begin
                  state_in    = ST_FILL;
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // head of chain is the last value when nothing stands behind it
   assign rsp_final_value = !status.second_occupied;
   assign rsp_overflowed  = overflow_ff;

   // a value dropped on a full store marks the run
   `PIS_ASSERT_NEXT(a_drop_marks, req_valid && req_ready && status.full, overflow_ff)
   // the final transfer clears the overflow mark for the next run
   `PIS_ASSERT_NEXT(a_final_clears, rsp_valid && rsp_ready && rsp_final_value, !overflow_ff)
   // no input taken while results are still going out
   `PIS_ASSERT_NOW(a_one_side, rsp_valid, !req_ready && !cmd.insert)

endmodule

/* rtl/pixel_insertion_sorter.sv */
// Latency: the first sorted value is offered the cycle after the run_end transfer.
// Throughput: one pixel per cycle while filling; the stored values of a run then drain
// one result per cycle while rsp_ready is high, set by the shift-out of the
// cell chain, and input is held off until the final result transfers.
// Reset: synchronous; empties every cell, clears the overflow mark, returns to filling.
`include "pixel_insertion_sorter_defines.svh"

module pixel_insertion_sorter
   import pis_pkg::*;
#(
   parameter int MAX_ITEMS = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pixel_value,
   input  logic       req_run_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_sorted_value,
   output logic       rsp_final_value,
   output logic       rsp_overflowed
);

   cmd_type          cmd;
   chain_status_type status;
   link_type         cell_link [MAX_ITEMS];
   link_type         head_left;
   link_type         tail_right;

   // sequencer
   pis_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .req_run_end     (req_run_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_final_value (rsp_final_value),
      .rsp_overflowed  (rsp_overflowed),
      .status          (status),
      .cmd             (cmd)
   );

   // chain ends: an always-occupied, never-greater cell on the left, empty on the right
   assign head_left  = '{occupied: 1'b1, greater: 1'b0, value: '0};
   assign tail_right = '{occupied: 1'b0, greater: 1'b0, value: '0};

   // row of cells
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      pis_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .left  ((i == 0) ? head_left : cell_link[(i == 0) ? 0 : i - 1]),
         .right ((i == MAX_ITEMS - 1) ? tail_right
                                      : cell_link[(i == MAX_ITEMS - 1) ? i : i + 1]),
         .self  (cell_link[i])
      );
   end

   // chain status for the sequencer
   assign status.full            = cell_link[MAX_ITEMS-1].occupied;
   assign status.second_occupied = cell_link[1].occupied;

   assign rsp_sorted_value = cell_link[0].value;

   // a result always comes from an occupied head cell
   `PIS_ASSERT_NOW(a_head_held, rsp_valid, cell_link[0].occupied)

   // occupied cells form a prefix and hold values in ascending order
   for (genvar j = 0; j < MAX_ITEMS - 1; j++) begin : g_chk
      `PIS_ASSERT_NOW(a_prefix, cell_link[j+1].occupied, cell_link[j].occupied)
      `PIS_ASSERT_NOW(a_order, cell_link[j+1].occupied,
                      cell_link[j].value <= cell_link[j+1].value)
   end

endmodule

/* bench/pixel_insertion_sorter_tb.sv */
`timescale 1ns / 1ps
// testbench for the pixel insertion sorter: pixel runs checked against a sorting predictor
module pixel_insertion_sorter_tb
   import pis_pkg::*;
;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;

   // one sorted pixel as it should leave the block
   typedef struct {
      pixel_type value;
      bit        last_of_run;
      bit        dropped;
   } sorted_pixel_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_pixel_value;
   logic       req_run_end;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_sorted_value;
   logic       rsp_final_value;
   logic       rsp_overflowed;

   // predictor state: the run held so far, kept ascending
   pixel_type        run_store [DEPTH];
   int               run_count   = 0;
   bit               run_dropped = 1'b0;
   sorted_pixel_type sorted_q [$];
   sorted_pixel_type head_pixel;

   int error_count        = 0;
   int cycle_count        = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   pixel_insertion_sorter #(.MAX_ITEMS(DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .req_run_end      (req_run_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_value  (rsp_final_value),
      .rsp_overflowed   (rsp_overflowed)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL pixel_insertion_sorter");
      $finish;
   end

   // receiver: random stalls on the result channel
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // insert one accepted pixel; a flagged pixel releases the whole run in order
   function automatic void predict_sorted_run(input pixel_type value, input bit last);
      int pos;
      int k;
      sorted_pixel_type item;
      if (run_count < DEPTH) begin
         pos = run_count;
         // equal values stay ahead of the newcomer
         while (pos > 0 && run_store[pos-1] > value) begin
            run_store[pos] = run_store[pos-1];
            pos--;
         end
         run_store[pos] = value;
         run_count++;
      end else begin
         run_dropped = 1'b1;
      end
      if (last) begin
         for (k = 0; k < run_count; k++) begin
            item.value       = run_store[k];
            item.last_of_run = (k == run_count - 1);
            item.dropped     = run_dropped;
            sorted_q.push_back(item);
         end
         run_count   = 0;
         run_dropped = 1'b0;
      end
   endfunction

   // check every result transfer against the oldest pending pixel
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_q.size() == 0) begin
            report_mismatch("transfer with nothing pending, sorted_value",
                            rsp_sorted_value, -1);
         end else begin
            head_pixel = sorted_q.pop_front();
            if (rsp_sorted_value !== head_pixel.value)
               report_mismatch("sorted_value", rsp_sorted_value, head_pixel.value);
            if (rsp_final_value !== head_pixel.last_of_run)
               report_mismatch("final_value", rsp_final_value, head_pixel.last_of_run);
            if (rsp_overflowed !== head_pixel.dropped)
               report_mismatch("overflowed", rsp_overflowed, head_pixel.dropped);
         end
      end
   end

   // send one pixel; returns at the edge of its transfer with valid still high
   task automatic send_pixel(input pixel_type value, input bit last);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_pixel_value = value;
      req_run_end     = last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_sorted_run(value, last);
   endtask

   // hold the input until every pending result has come out
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sorted_q.size() != 0) @(negedge clock);
   endtask

   // one-pixel runs at both ends of the range
   task automatic test_single_pixel_runs();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b1);
   endtask

   // extremes mixed with duplicates, then a full pause until drained
   task automatic test_extremes_and_duplicates();
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b1);
      wait_drained();
   endtask

   // descending run past capacity: an unflagged pixel and the flagged one are dropped
   task automatic test_overflow_run();
      int k;
      for (k = 0; k < DEPTH + 2; k++)
         send_pixel(pixel_type'(255 - 15 * k), k == DEPTH + 1);
      wait_drained();
   endtask

   // random runs: mostly mid length, some tiny, some around capacity
   task automatic test_random_runs(input int items, input int idle_pct, input int stall_pct);
      int sent;
      int run_len;
      int span;
      int k;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(0, 9))
            0, 1: run_len = $urandom_range(1, 3);
            2, 3: run_len = $urandom_range(DEPTH - 1, DEPTH + 4);
            default: run_len = $urandom_range(4, DEPTH);
         endcase
         // a narrow span forces many equal values
         span = ($urandom_range(0, 3) == 0) ? 3 : 255;
         for (k = 0; k < run_len; k++)
            send_pixel(pixel_type'($urandom_range(0, span)), k == run_len - 1);
         sent += run_len;
      end
      wait_drained();
   endtask

   // main sequence
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pixel_value = 8'd0;
      req_run_end     = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_pixel_runs();
      test_extremes_and_duplicates();
      test_overflow_run();
      test_random_runs(22, 0, 0);
      test_random_runs(22, 87, 0);
      test_random_runs(22, 0, 87);
      test_random_runs(22, 32, 32);

      repeat (DEPTH + 4) @(posedge clock);
      if (error_count == 0)
         $display("PASS pixel_insertion_sorter");
      else
         $display("FAIL pixel_insertion_sorter");
      $finish;
   end

endmodule
